// ===== rtl/hr8d_pkg.sv =====
// ----------------------------------------------------------------------------
// hr8d_pkg: shared types and constants for the hex real to double converter
// Payload structs and the exponent offset used by the pipeline.
// ----------------------------------------------------------------------------
package hr8d_pkg;

  localparam int unsigned FracW = 56;
  localparam int unsigned SigW  = 53;
  localparam int unsigned PosW  = 6;   // leading-one position 0..55

  // 1023 - 4*64 - 56
  localparam logic [10:0] ExpOffset = 11'd711;

  typedef struct packed {
    logic        in_sign;
    logic [6:0]  hex_exponent;
    logic [55:0] hex_fraction;
  } hr8d_in_t;

  typedef struct packed {
    logic        out_sign;
    logic [10:0] out_exponent;
    logic [51:0] out_fraction;
  } hr8d_out_t;

endpackage

// ===== rtl/hex_real8_to_ieee_double_core.sv =====
// Four register stages lie between the input request and the output register.
// Throughput: one request per cycle; a stall freezes all stages together.
// Stages: leading-one search, normalizing shift, rounding, exponent and output.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// hex_real8_to_ieee_double_core: IBM hex 64-bit real to IEEE 754 double
// Four-stage pipeline: find leading one, shift, round to nearest even, pack.
// ----------------------------------------------------------------------------
module hex_real8_to_ieee_double_core
  import hr8d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hr8d_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hr8d_out_t out_data_o
);

  logic adv;
  assign adv        = !out_stall_i;
  assign in_stall_o = out_stall_i;

  // stage 1: leading-one position
  logic            v1_q;
  logic            s1_q;
  logic [6:0]      e1_q;
  logic [55:0]     f1_q;
  logic [PosW-1:0] p1_q;
  logic [PosW-1:0] p1_d;

  always_comb begin
    p1_d = '0;
    for (int i = 0; i < 56; i++) begin
      if (in_data_i.hex_fraction[i]) p1_d = PosW'(i);
    end
  end

  // stage 2: normalize so the leading one sits at bit 55
  logic            v2_q;
  logic            s2_q;
  logic            z2_q;
  logic [6:0]      e2_q;
  logic [55:0]     n2_q;
  logic [PosW-1:0] p2_q;

  // stage 3: round to 53 bits, keep carry
  logic            v3_q;
  logic            s3_q;
  logic            z3_q;
  logic [6:0]      e3_q;
  logic [PosW-1:0] p3_q;
  logic [53:0]     m3_q;
  logic [53:0]     m3_d;
  logic            rnd;

  // bits 2..0 of the normalized word: guard, then sticky
  assign rnd  = n2_q[2] && (n2_q[1] || n2_q[0] || n2_q[3]);
  assign m3_d = {1'b0, n2_q[55:3]} + 54'(rnd);

  // stage 4: output register
  logic            v4_q;
  hr8d_out_t       o4_q;
  hr8d_out_t       o4_d;
  logic [10:0]     exp_sum;

  always_comb begin
    exp_sum = 11'(p3_q) + {2'b00, e3_q, 2'b00} + ExpOffset + 11'(m3_q[53]);
    o4_d.out_sign = s3_q;
    if (z3_q) begin
      o4_d.out_exponent = '0;
      o4_d.out_fraction = '0;
    end else begin
      o4_d.out_exponent = exp_sum;
      o4_d.out_fraction = m3_q[53] ? m3_q[52:1] : m3_q[51:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= in_data_i.in_sign;
      e1_q <= in_data_i.hex_exponent;
      f1_q <= in_data_i.hex_fraction;
      p1_q <= p1_d;

      s2_q <= s1_q;
      z2_q <= (f1_q == '0);
      e2_q <= e1_q;
      p2_q <= p1_q;
      n2_q <= f1_q << (6'd55 - p1_q);

      s3_q <= s2_q;
      z3_q <= z2_q;
      e3_q <= e2_q;
      p3_q <= p2_q;
      m3_q <= m3_d;

      o4_q <= o4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = o4_q;

  a_sign_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q) |=> (out_data_o.out_sign == $past(s3_q)))
    else $error("sign not carried to output");
  a_zero_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_exponent == '0) |-> (out_data_o.out_fraction == '0))
    else $error("zero exponent with nonzero fraction");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !z2_q) |-> n2_q[55])
    else $error("normalized word lacks leading one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(out_valid_o) && $stable(out_data_o)))
    else $error("output changed under stall");

endmodule
